### rtl/core/phist_pkg.sv
`default_nettype none
package phist_pkg;

  localparam int POS_BITS   = 32;
  localparam int WIDTH_BITS = 31;
  localparam int BINS_BITS  = 7;
  localparam int QUO_BITS   = 7;   // quotient range covers 0..127, enough for 64 bins
  localparam int IDXO_BITS  = 6;
  localparam int TOTAL_BITS = 16;
  localparam int SUM_BITS   = 17;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 16'hFFFF;
  localparam logic [SUM_BITS-1:0]   SUM_MAX   = 17'h1FFFF;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RST  = 31'd65536;
  localparam logic [POS_BITS-1:0]   OFFSET_RST = 32'd0;
  localparam logic [BINS_BITS-1:0]  BINS_RST   = 7'd50;

  localparam logic [CFG_IDX_BITS-1:0] CFG_BIN_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_OFFSET  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BINS_IN_USE = 2'd2;

  // bin range that one sample falls into
  typedef struct packed {
    logic                hit;
    logic [QUO_BITS-1:0] lo;
    logic [QUO_BITS-1:0] hi;
  } div_res_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_all;
  } st_req_t;

endpackage
`default_nettype wire

### rtl/core/phist_div.sv
`default_nettype none
module phist_div (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic [phist_pkg::POS_BITS-1:0]      pos,
  input  wire logic [phist_pkg::POS_BITS-1:0]      offset,
  input  wire logic [phist_pkg::WIDTH_BITS-1:0]    width,
  input  wire logic [phist_pkg::BINS_BITS-1:0]     n_bins,
  output logic                                     done,
  output phist_pkg::div_res_t                      res
);
  import phist_pkg::*;

  localparam int REM_BITS = WIDTH_BITS + QUO_BITS;

  typedef enum logic [1:0] {S_IDLE, S_ITER, S_FIN} dstate_t;

  dstate_t               st_r, st_nxt;
  logic [REM_BITS-1:0]   rem_r, rem_nxt;
  logic [REM_BITS-1:0]   dsr_r, dsr_nxt;
  logic [QUO_BITS-1:0]   quo_r, quo_nxt;
  logic [2:0]            step_r, step_nxt;
  logic                  skip_r, skip_nxt;
  logic                  w0_r, w0_nxt;
  logic                  zero_r, zero_nxt;
  logic [BINS_BITS-1:0]  n_r, n_nxt;
  logic                  done_r, done_nxt;
  div_res_t              res_r, res_nxt;

  logic [POS_BITS:0]     d_sum;
  logic                  too_big;
  logic                  ge;
  logic [QUO_BITS-1:0]   q_lo;
  logic [QUO_BITS-1:0]   q_hi;

  assign d_sum   = {pos[POS_BITS-1], pos} + {offset[POS_BITS-1], offset};
  assign too_big = {{(REM_BITS-POS_BITS-1){1'b0}}, d_sum} >= {width, {QUO_BITS{1'b0}}};
  assign ge      = rem_r >= dsr_r;

  // a remainder of zero puts the sample on the upper edge of bin q-1 as well
  assign q_lo = (rem_r == '0 && quo_r != '0) ? quo_r - 1'b1 : quo_r;
  assign q_hi = (quo_r < n_r) ? quo_r : n_r - 1'b1;

  always_comb begin
    st_nxt   = st_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    skip_nxt = skip_r;
    w0_nxt   = w0_r;
    zero_nxt = zero_r;
    n_nxt    = n_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          rem_nxt  = {{(REM_BITS-POS_BITS-1){1'b0}}, d_sum};
          dsr_nxt  = {1'b0, width, {(QUO_BITS-1){1'b0}}};
          quo_nxt  = '0;
          step_nxt = 3'(QUO_BITS - 1);
          w0_nxt   = width == '0;
          zero_nxt = d_sum == '0;
          skip_nxt = d_sum[POS_BITS] || too_big;
          n_nxt    = n_bins;
          st_nxt   = (d_sum[POS_BITS] || too_big || width == '0) ? S_FIN : S_ITER;
        end
      end
      S_ITER: begin
        if (ge) begin
          rem_nxt = rem_r - dsr_r;
        end
        quo_nxt  = {quo_r[QUO_BITS-2:0], ge};
        dsr_nxt  = dsr_r >> 1;
        step_nxt = step_r - 3'd1;
        if (step_r == '0) begin
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        done_nxt = 1'b1;
        st_nxt   = S_IDLE;
        if (w0_r) begin
          // zero width: every bin collapses onto one point
          res_nxt = '{hit: zero_r && n_r != '0, lo: '0, hi: n_r - 1'b1};
        end else if (skip_r) begin
          res_nxt = '{hit: 1'b0, lo: '0, hi: '0};
        end else begin
          res_nxt = '{hit: q_lo < n_r, lo: q_lo, hi: q_hi};
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
    skip_r <= skip_nxt;
    w0_r   <= w0_nxt;
    zero_r <= zero_nxt;
    n_r    <= n_nxt;
    res_r  <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

### rtl/core/phist_store.sv
`default_nettype none
module phist_store #(
  parameter int NUM_BINS   = 64,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire phist_pkg::st_req_t              req,
  input  wire logic [$clog2(NUM_BINS)-1:0]     rd_addr,
  input  wire logic [$clog2(NUM_BINS)-1:0]     wr_addr,
  input  wire logic [COUNT_BITS-1:0]           wr_data,
  output logic [COUNT_BITS-1:0]                rd_data
);
  import phist_pkg::*;

  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]   vld_r;
  logic [COUNT_BITS-1:0] rdat_r;
  logic                  rvld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rdat_r <= mem[rd_addr];
    end
  end

  // entries never written since the last readout read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.clr_all) begin
        vld_r <= '0;
      end else if (req.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdat_r : '0;

endmodule
`default_nettype wire

### rtl/core/position_histogram_1d_top.sv
`default_nettype none
// Sample beat: 7-step restoring divide for the bin index, then one memory read-modify-write
// per counted bin; the divide is skipped for zero width, below bin 0 or far past the top. A new
// sample is taken only once the previous one, and any readout it starts, is done. A last beat
// adds a readout of one result per bin in use, held by output stalls. One result register on output.
// Reset (rst_n, synchronous): registers to 65536 / 0 / 50, all counts read as zero at once.
module position_histogram_1d_top #(
  parameter int NUM_BINS   = 64,
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] position
  input  wire logic        in_tlast,   // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [5:0] bin_index, [21:6] bin_total, [38:22] running_sum
  output logic             out_tlast,  // last_bin
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import phist_pkg::*;

  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int EXT_W = (COUNT_BITS > SUM_BITS) ? COUNT_BITS : SUM_BITS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_CNT_RD, ST_CNT_WR, ST_RO_RD, ST_RO_EMIT
  } state_t;

  state_t                  st_r, st_nxt;
  logic [IDX_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        hi_r, hi_nxt;
  logic                    last_r, last_nxt;
  logic [SUM_BITS-1:0]     sum_r, sum_nxt;
  logic                    ov_r, ov_nxt;
  logic [IDXO_BITS-1:0]    oidx_r, oidx_nxt;
  logic [TOTAL_BITS-1:0]   otot_r, otot_nxt;
  logic [SUM_BITS-1:0]     osum_r, osum_nxt;
  logic                    olast_r, olast_nxt;

  logic [WIDTH_BITS-1:0]   width_r;
  logic [POS_BITS-1:0]     offset_r;
  logic [BINS_BITS-1:0]    bins_r;
  logic [BINS_BITS-1:0]    n_eff;

  logic                    div_start;
  logic                    div_done;
  div_res_t                div_res;

  st_req_t                 sreq;
  logic [COUNT_BITS-1:0]   rdata;
  logic [COUNT_BITS-1:0]   wdata;

  logic                    out_free;
  logic [EXT_W-1:0]        cnt_ext;
  logic [TOTAL_BITS-1:0]   tot;
  logic [SUM_BITS:0]       sum_wide;
  logic [SUM_BITS-1:0]     sum_sat;
  logic                    ro_last;

  assign n_eff     = (bins_r > BINS_BITS'(NUM_BINS)) ? BINS_BITS'(NUM_BINS) : bins_r;
  assign in_tready = st_r == ST_IDLE;
  assign div_start = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      offset_r <= OFFSET_RST;
      bins_r   <= BINS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BIN_WIDTH:   width_r  <= cfg_data[WIDTH_BITS-1:0];
        CFG_LOW_OFFSET:  offset_r <= cfg_data;
        CFG_BINS_IN_USE: bins_r   <= cfg_data[BINS_BITS-1:0];
        default: ;
      endcase
    end
  end

  phist_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .pos    (in_tdata),
    .offset (offset_r),
    .width  (width_r),
    .n_bins (n_eff),
    .done   (div_done),
    .res    (div_res)
  );

  phist_store #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sreq),
    .rd_addr (cnt_r),
    .wr_addr (cnt_r),
    .wr_data (wdata),
    .rd_data (rdata)
  );

  // counters hold at all ones
  assign wdata = (&rdata) ? rdata : rdata + 1'b1;

  assign out_free = !ov_r || out_tready;
  assign cnt_ext  = EXT_W'(rdata);
  assign tot      = (cnt_ext > EXT_W'(TOTAL_MAX)) ? TOTAL_MAX : cnt_ext[TOTAL_BITS-1:0];
  assign sum_wide = {1'b0, sum_r} + (SUM_BITS+1)'(tot);
  assign sum_sat  = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
  assign ro_last  = BINS_BITS'(cnt_r) + 1'b1 == n_eff;

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    hi_nxt    = hi_r;
    last_nxt  = last_r;
    sum_nxt   = sum_r;
    ov_nxt    = ov_r && !out_tready;
    oidx_nxt  = oidx_r;
    otot_nxt  = otot_r;
    osum_nxt  = osum_r;
    olast_nxt = olast_r;
    sreq      = '{rd_en: 1'b0, wr_en: 1'b0, clr_all: 1'b0};
    case (st_r)
      ST_IDLE: begin
        if (div_start) begin
          last_nxt = in_tlast;
          st_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          cnt_nxt = div_res.lo[IDX_W-1:0];
          hi_nxt  = div_res.hi[IDX_W-1:0];
          sum_nxt = '0;
          if (div_res.hit) begin
            st_nxt = ST_CNT_RD;
          end else if (last_r) begin
            cnt_nxt = '0;
            if (n_eff == '0) begin
              sreq.clr_all = 1'b1;
              st_nxt       = ST_IDLE;
            end else begin
              st_nxt = ST_RO_RD;
            end
          end else begin
            st_nxt = ST_IDLE;
          end
        end
      end
      ST_CNT_RD: begin
        sreq.rd_en = 1'b1;
        st_nxt     = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        sreq.wr_en = 1'b1;
        if (cnt_r == hi_r) begin
          // a hit implies at least one bin in use, so readout always has work
          cnt_nxt = '0;
          st_nxt  = last_r ? ST_RO_RD : ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          st_nxt  = ST_CNT_RD;
        end
      end
      ST_RO_RD: begin
        sreq.rd_en = 1'b1;
        st_nxt     = ST_RO_EMIT;
      end
      ST_RO_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oidx_nxt  = IDXO_BITS'(cnt_r);
          otot_nxt  = tot;
          osum_nxt  = sum_sat;
          olast_nxt = ro_last;
          sum_nxt   = sum_sat;
          if (ro_last) begin
            sreq.clr_all = 1'b1;
            st_nxt       = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
            st_nxt  = ST_RO_RD;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    cnt_r   <= cnt_nxt;
    hi_r    <= hi_nxt;
    last_r  <= last_nxt;
    sum_r   <= sum_nxt;
    oidx_r  <= oidx_nxt;
    otot_r  <= otot_nxt;
    osum_r  <= osum_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, osum_r, otot_r, oidx_r};
  assign out_tlast  = olast_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> st_r == ST_DIV)
    else $error("divider finished outside the divide wait");

  a_sweep_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_CNT_WR |-> cnt_r <= hi_r && BINS_BITS'(hi_r) < n_eff)
    else $error("count sweep ran past its range");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RO_EMIT |-> BINS_BITS'(cnt_r) < n_eff)
    else $error("readout bin beyond bins in use");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> $stable(out_tdata) && ov_r)
    else $error("pending result beat overwritten");

  a_ro_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RO_EMIT && !$past(st_r == ST_RO_EMIT) |-> $past(st_r == ST_RO_RD))
    else $error("readout emit without memory read");

endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import phist_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;  // unmapped index, write is dropped
  localparam int NBINS = 64;
  localparam int CNT_MAX = 65535;
  localparam int SETTLE = 300;  // worst sample: divide plus 64 read-modify-writes

  typedef struct packed {
    logic [IDXO_BITS-1:0]  idx;
    logic [TOTAL_BITS-1:0] total;
    logic [SUM_BITS-1:0]   sum;
    logic                  last;
  } bin_report_t;

  class histogram_board;
    int unsigned bin_counts[NBINS];
    logic [WIDTH_BITS-1:0] width;
    logic [POS_BITS-1:0]   offset;
    logic [BINS_BITS-1:0]  nbins;
    bin_report_t bin_reports[$];
    int errors;

    function void reset();
      foreach (bin_counts[i]) bin_counts[i] = 0;
      width = WIDTH_RST;
      offset = OFFSET_RST;
      nbins = BINS_RST;
      bin_reports.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_BIN_WIDTH:   width = data[WIDTH_BITS-1:0];
        CFG_LOW_OFFSET:  offset = data;
        CFG_BINS_IN_USE: nbins = data[BINS_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return bin_reports.size();
    endfunction

    function void note_sample(logic [31:0] pos, logic is_last);
      longint p, w, off, lo, hi;
      int n;
      int unsigned sum, c;
      bin_report_t r;
      p = longint'($signed(pos));
      w = longint'(width);
      off = longint'($signed(offset));
      n = (nbins > NBINS) ? NBINS : int'(nbins);
      for (int i = 0; i < n; i++) begin
        lo = longint'(i) * w - off;
        hi = longint'(i + 1) * w - off;
        if (lo <= p && p <= hi && bin_counts[i] < CNT_MAX) bin_counts[i]++;
      end
      if (!is_last) return;
      sum = 0;
      for (int i = 0; i < n; i++) begin
        c = (bin_counts[i] > TOTAL_MAX) ? TOTAL_MAX : bin_counts[i];
        sum += c;
        if (sum > SUM_MAX) sum = SUM_MAX;
        r.idx = i[IDXO_BITS-1:0];
        r.total = c[TOTAL_BITS-1:0];
        r.sum = sum[SUM_BITS-1:0];
        r.last = (i + 1 == n);
        bin_reports.push_back(r);
      end
      foreach (bin_counts[i]) bin_counts[i] = 0;
    endfunction

    function void check_result(logic [39:0] data, logic last_flag);
      bin_report_t e;
      if (bin_reports.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual data %h last %b",
                 $time, data, last_flag);
        errors++;
        return;
      end
      e = bin_reports.pop_front();
      if (data[5:0] !== e.idx) begin
        $display("%0t: bin_index expected %0d actual %0d", $time, e.idx, data[5:0]);
        errors++;
      end
      if (data[21:6] !== e.total) begin
        $display("%0t: bin_total (bin %0d) expected %0d actual %0d",
                 $time, e.idx, e.total, data[21:6]);
        errors++;
      end
      if (data[38:22] !== e.sum) begin
        $display("%0t: running_sum (bin %0d) expected %0d actual %0d",
                 $time, e.idx, e.sum, data[38:22]);
        errors++;
      end
      if (last_flag !== e.last) begin
        $display("%0t: last_bin (bin %0d) expected %b actual %b",
                 $time, e.idx, e.last, last_flag);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  bit long_hold = 1'b0;
  histogram_board sb;

  position_histogram_1d_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("FAIL position_histogram_1d_top");
    $finish;
  end

  // handshake values are stable at the falling edge, so beats are judged there
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else if (out_idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [31:0] pos, input logic is_last);
    bit rdy;
    if (in_idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pos;
    in_tlast <= is_last;
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    sb.note_sample(pos, is_last);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
    bit rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    sb.set_reg(idx, data);
  endtask

  // unused upper bits carry junk to show they are dropped
  task automatic set_config(input logic [WIDTH_BITS-1:0] w, input logic [31:0] off,
                            input logic [BINS_BITS-1:0] n);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(CFG_BIN_WIDTH, {junk[0], w});
    write_reg(CFG_LOW_OFFSET, off);
    write_reg(CFG_BINS_IN_USE, {junk[31:7], n});
    if (junk[1]) write_reg(CFG_SPARE, $urandom());
    cfg_valid <= 1'b0;
  endtask

  // wait until every readout is out, then let a pending sample finish
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_position(logic [WIDTH_BITS-1:0] w, logic [31:0] off,
                                                int n);
    longint base;
    int b, r;
    r = $urandom_range(0, 9);
    if (r < 2 || n == 0) return $urandom();
    b = $urandom_range(0, n - 1);
    base = longint'(b) * longint'(w) - longint'($signed(off));
    if (r < 4) return base[31:0];
    if (r == 4) return 32'(base + longint'(w) + 1);
    return 32'(base + longint'($urandom_range(0, w)));
  endfunction

  initial begin
    logic [WIDTH_BITS-1:0] w;
    logic [31:0] off, rv;
    int n, rand_items, phase_items, phase_goal, set_len, ph;

    sb = new();
    sb.reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: unit bins 0..49, edges, outside, extremes
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'h0032_0000, 1'b0);
    send_sample(32'h0032_0001, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0000_8000, 1'b0);
    send_sample(32'h0003_0000, 1'b1);
    drain();

    // zero width: every bin collapses to the point -1.0
    set_config('0, 32'h0001_0000, 7'd5);
    send_sample(32'hFFFF_0000, 1'b0);
    send_sample(32'hFFFF_0001, 1'b0);
    send_sample(32'hFFFF_0000, 1'b1);
    drain();

    // no bins: readout is empty but still clears
    set_config(31'd65536, 32'h0000_0000, 7'd0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0001_0000, 1'b1);
    drain();

    // bin count above the array size clamps to 64
    set_config(31'd65536, 32'h0000_0000, 7'd70);
    send_sample(32'h003F_0000, 1'b0);
    send_sample(32'h0040_0000, 1'b1);
    drain();

    set_config(31'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd64);
    send_sample(32'h8000_0001, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    drain();

    write_reg(CFG_SPARE, $urandom());
    set_config(31'd1, 32'h8000_0000, 7'd1);
    send_sample(32'h7FFF_FFFF, 1'b1);
    drain();

    rand_items = 0;
    ph = 0;
    while (rand_items < 290) begin
      rv = $urandom();
      case ($urandom_range(0, 3))
        0: w = 31'($urandom_range(1, 16));
        1: w = 31'($urandom_range(1, 1 << 17));
        2: w = 31'($urandom_range(1 << 16, 1 << 24));
        default: w = (rv[30:0] == '0) ? 31'd1 : rv[30:0];
      endcase
      n = ($urandom_range(0, 3) == 0 || ph == 1) ? 64 : $urandom_range(1, 64);
      case ($urandom_range(0, 2))
        0: off = '0;
        1: off = $urandom();
        default: off = 32'(longint'($urandom_range(0, n)) * longint'(w));
      endcase
      set_config(w, off, n[BINS_BITS-1:0]);
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      if (ph == 1) long_hold = 1'b1;  // sender keeps offering through the hold-off
      phase_goal = $urandom_range(25, 50);
      phase_items = 0;
      while (phase_items < phase_goal) begin
        set_len = $urandom_range(1, 10);
        for (int k = 0; k < set_len; k++)
          send_sample(pick_position(w, off, n), k == set_len - 1);
        phase_items += set_len;
      end
      rand_items += phase_items;
      ph++;
      drain();
    end

    // three coincident bins back to back, no idling from here on
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    set_config('0, 32'h0000_0000, 7'd3);
    repeat (10) send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    drain();

    if (sb.errors == 0) begin
      $display("PASS position_histogram_1d_top");
    end else begin
      $display("FAIL position_histogram_1d_top");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/phist_pkg.sv
rtl/core/phist_div.sv
rtl/core/phist_store.sv
rtl/core/position_histogram_1d_top.sv
test/tb_top.sv
